@@ rtl/quicksort_sequence_sorter_top_macros.svh @@
// Assertion macros shared by the sorter RTL.
// Each expects clk and rst_n in scope of the module that uses it.
`ifndef QUICKSORT_SEQUENCE_SORTER_TOP_MACROS_SVH
`define QUICKSORT_SEQUENCE_SORTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qss_pkg.sv @@
package qss_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    // Input transaction payload
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflow;
    } out_t;

    // Element store write from the load side
    typedef struct packed {
        logic              wr;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } load_t;

    // Sort request handed to the engine at the end of a run
    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] n;
        logic             dropped;
    } sort_req_t;

    // Sort and output sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_RD,
        ST_PIV_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_WAIT,
        ST_FIN_PUT,
        ST_DECIDE,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

endpackage

@@ rtl/qss_engine.sv @@
`include "quicksort_sequence_sorter_top_macros.svh"

module qss_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  qss_pkg::load_t     load,
    input  qss_pkg::sort_req_t req,
    output logic              busy,
    output logic              strobe,
    output qss_pkg::out_t      result
);

    localparam int IDX_W  = qss_pkg::IDX_W;
    localparam int CNT_W  = qss_pkg::CNT_W;
    localparam int DATA_W = qss_pkg::DATA_W;

    // Element store and range stack
    logic [DATA_W-1:0]  store [qss_pkg::MAX_ITEMS];
    logic [2*IDX_W-1:0] stack [qss_pkg::MAX_ITEMS];

    qss_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              dropped_reg, dropped_next;
    logic [DATA_W-1:0] pivot_reg, pivot_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;

    logic [DATA_W-1:0]  rd_data_reg;
    logic [2*IDX_W-1:0] stk_data_reg;

    // Store port controls
    logic              eng_we;
    logic [IDX_W-1:0]  eng_waddr;
    logic [DATA_W-1:0] eng_wdata;
    logic [IDX_W-1:0]  rd_addr;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr;
    logic [2*IDX_W-1:0] stk_wdata;
    logic [IDX_W-1:0]  stk_raddr;

    logic              is_less;
    logic              is_final;

    // Compare unit: signed element against pivot
    assign is_less  = $signed(rd_data_reg) < $signed(pivot_reg);
    assign is_final = ({1'b0, k_reg} == (n_reg - 1'b1));

    // Element store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (load.wr)
        begin
            store[load.addr] <= load.data;
        end
        else if (eng_we)
        begin
            store[eng_waddr] <= eng_wdata;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Range stack: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack[stk_waddr] <= stk_wdata;
        end
        stk_data_reg <= stack[stk_raddr];
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qss_pkg::ST_IDLE;
            lo_reg      <= '0;
            hi_reg      <= '0;
            k_reg       <= '0;
            slot_reg    <= '0;
            sp_reg      <= '0;
            n_reg       <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            k_reg       <= k_next;
            slot_reg    <= slot_next;
            sp_reg      <= sp_next;
            n_reg       <= n_next;
            dropped_reg <= dropped_next;
        end
    end

    // Data holding registers
    always_ff @(posedge clk)
    begin
        pivot_reg <= pivot_next;
        tmp_reg   <= tmp_next;
    end

    // Next state and port controls
    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        slot_next    = slot_reg;
        sp_next      = sp_reg;
        n_next       = n_reg;
        dropped_next = dropped_reg;
        pivot_next   = pivot_reg;
        tmp_next     = tmp_reg;
        eng_we       = 1'b0;
        eng_waddr    = k_reg;
        eng_wdata    = rd_data_reg;
        rd_addr      = k_reg;
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[IDX_W-1:0];
        stk_wdata    = {lo_reg, hi_reg};
        stk_raddr    = sp_reg[IDX_W-1:0] - 1'b1;
        strobe       = 1'b0;

        unique case (state_reg)
            qss_pkg::ST_IDLE:
            begin
                if (req.go)
                begin
                    n_next       = req.n;
                    dropped_next = req.dropped;
                    state_next   = qss_pkg::ST_INIT;
                end
            end
            qss_pkg::ST_INIT:
            begin
                lo_next    = '0;
                hi_next    = IDX_W'(n_reg - 1'b1);
                sp_next    = '0;
                state_next = qss_pkg::ST_CHECK;
            end
            qss_pkg::ST_CHECK:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = qss_pkg::ST_PIV_RD;
                end
                else if (sp_reg != '0)
                begin
                    state_next = qss_pkg::ST_POP;
                end
                else
                begin
                    k_next     = '0;
                    state_next = qss_pkg::ST_OUT_RD;
                end
            end
            qss_pkg::ST_POP:
            begin
                // Read the top entry and drop it
                sp_next    = sp_reg - 1'b1;
                state_next = qss_pkg::ST_POP_WAIT;
            end
            qss_pkg::ST_POP_WAIT:
            begin
                lo_next    = stk_data_reg[2*IDX_W-1:IDX_W];
                hi_next    = stk_data_reg[IDX_W-1:0];
                state_next = qss_pkg::ST_CHECK;
            end
            qss_pkg::ST_PIV_RD:
            begin
                rd_addr    = hi_reg;
                k_next     = lo_reg;
                slot_next  = lo_reg;
                state_next = qss_pkg::ST_PIV_WAIT;
            end
            qss_pkg::ST_PIV_WAIT:
            begin
                pivot_next = rd_data_reg;
                state_next = qss_pkg::ST_SCAN_RD;
            end
            qss_pkg::ST_SCAN_RD:
            begin
                if (k_reg < hi_reg)
                begin
                    rd_addr    = k_reg;
                    state_next = qss_pkg::ST_SCAN_CMP;
                end
                else
                begin
                    rd_addr    = slot_reg;
                    state_next = qss_pkg::ST_FIN_WAIT;
                end
            end
            qss_pkg::ST_SCAN_CMP:
            begin
                priority if (is_less && (slot_reg != k_reg))
                begin
                    // Hold the scanned element and fetch the slot element
                    tmp_next   = rd_data_reg;
                    rd_addr    = slot_reg;
                    state_next = qss_pkg::ST_SWAP_A;
                end
                else if (is_less)
                begin
                    slot_next  = slot_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = qss_pkg::ST_SCAN_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = qss_pkg::ST_SCAN_RD;
                end
            end
            qss_pkg::ST_SWAP_A:
            begin
                eng_we     = 1'b1;
                eng_waddr  = k_reg;
                eng_wdata  = rd_data_reg;
                state_next = qss_pkg::ST_SWAP_B;
            end
            qss_pkg::ST_SWAP_B:
            begin
                eng_we     = 1'b1;
                eng_waddr  = slot_reg;
                eng_wdata  = tmp_reg;
                slot_next  = slot_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = qss_pkg::ST_SCAN_RD;
            end
            qss_pkg::ST_FIN_WAIT:
            begin
                // Move the slot element to the tail
                eng_we     = 1'b1;
                eng_waddr  = hi_reg;
                eng_wdata  = rd_data_reg;
                state_next = qss_pkg::ST_FIN_PUT;
            end
            qss_pkg::ST_FIN_PUT:
            begin
                eng_we     = 1'b1;
                eng_waddr  = slot_reg;
                eng_wdata  = pivot_reg;
                state_next = qss_pkg::ST_DECIDE;
            end
            qss_pkg::ST_DECIDE:
            begin
                // Push the larger part, continue on the smaller one
                if ((slot_reg - lo_reg) < (hi_reg - slot_reg))
                begin
                    if ((({1'b0, slot_reg} + 1'b1) < {1'b0, hi_reg}) &&
                        (sp_reg < CNT_W'(qss_pkg::MAX_ITEMS)))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = {slot_reg + 1'b1, hi_reg};
                        sp_next   = sp_reg + 1'b1;
                    end
                    hi_next = (slot_reg == lo_reg) ? lo_reg : slot_reg - 1'b1;
                end
                else
                begin
                    if ((({1'b0, lo_reg} + 1'b1) < {1'b0, slot_reg}) &&
                        (sp_reg < CNT_W'(qss_pkg::MAX_ITEMS)))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = {lo_reg, slot_reg - 1'b1};
                        sp_next   = sp_reg + 1'b1;
                    end
                    lo_next = (slot_reg == hi_reg) ? hi_reg : slot_reg + 1'b1;
                end
                state_next = qss_pkg::ST_CHECK;
            end
            qss_pkg::ST_OUT_RD:
            begin
                rd_addr    = k_reg;
                state_next = qss_pkg::ST_OUT_EMIT;
            end
            qss_pkg::ST_OUT_EMIT:
            begin
                strobe = 1'b1;
                if (is_final)
                begin
                    state_next = qss_pkg::ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = qss_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = qss_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy                = (state_reg != qss_pkg::ST_IDLE);
    assign result.sorted_value = rd_data_reg;
    assign result.final_res    = is_final;
    assign result.overflow     = dropped_reg;

    `QSS_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= CNT_W'(qss_pkg::MAX_ITEMS),
        "range stack pointer beyond capacity")
    `QSS_ASSERT_NOW(a_scan_order, state_reg == qss_pkg::ST_SCAN_RD,
        (lo_reg <= slot_reg) && (slot_reg <= k_reg) && (k_reg <= hi_reg),
        "partition indices out of order")
    `QSS_ASSERT_NOW(a_pivot_in_range, state_reg == qss_pkg::ST_DECIDE,
        (lo_reg <= slot_reg) && (slot_reg <= hi_reg),
        "pivot position outside its range")
    `QSS_ASSERT_NEXT(a_final_idle, strobe && result.final_res,
        state_reg == qss_pkg::ST_IDLE, "no return to idle after final result")

endmodule

@@ rtl/quicksort_sequence_sorter_top.sv @@
// Channel   Handshake                  Payload
// item      start / busy (in)          value, last
// result    strobe (out, no stall)     sorted_value, final_res, overflow
//
// Loading accepts one item per cycle; busy stays low until the item marked last.
// Sorting runs on one element-store read port: each compare reads an element
// then tests it, each exchange writes both elements in turn, each partition
// also fetches and places the pivot, and each popped range is read first.
// Output reads each result before strobing it; after the final one busy drops and a new run may begin.
// Reset clears the run count and flags; the element store and range stack
// need no clearing since only entries written in the current run are read.

module quicksort_sequence_sorter_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  qss_pkg::in_t  item,
    output logic         strobe,
    output qss_pkg::out_t result
);

    localparam int CNT_W = qss_pkg::CNT_W;
    localparam int IDX_W = qss_pkg::IDX_W;

    logic               accept;
    logic               has_room;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    qss_pkg::load_t      load;
    qss_pkg::sort_req_t  req;

    assign accept   = start && !busy;
    assign has_room = (count_reg < CNT_W'(qss_pkg::MAX_ITEMS));

    // Store the transaction or flag it as dropped
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        load.wr      = accept && has_room;
        load.addr    = count_reg[IDX_W-1:0];
        load.data    = item.value;
        req.go       = accept && item.last;
        req.n        = has_room ? count_reg + 1'b1 : count_reg;
        req.dropped  = dropped_reg || !has_room;
        if (accept)
        begin
            if (item.last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else if (has_room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    qss_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .req    (req),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int DIR_ROWS = 23;

    // One row of the directed stimulus; want is used only where typed is set
    typedef struct packed {
        qss_pkg::in_t  stim;
        logic          typed;
        qss_pkg::out_t want;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    qss_pkg::in_t  item;
    logic          strobe;
    qss_pkg::out_t result;

    // Predictor state
    logic signed [qss_pkg::DATA_W-1:0] held_vals [qss_pkg::MAX_ITEMS];
    int                                held_count;
    logic                              drop_seen;
    qss_pkg::out_t                     fresh_q [$];
    qss_pkg::out_t                     sorted_exp_q [$];

    int            mismatch_count;
    int            cycle_count;
    int            burst_left;
    int            random_items;
    qss_pkg::out_t want_res;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // single-element runs at the extremes and at zero
        '{'{32'sh7FFF_FFFF, 1'b1}, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
        '{'{32'sh8000_0000, 1'b1}, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
        '{'{32'sh0000_0000, 1'b1}, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
        // two elements, descending
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{-32'sd5, 1'b1}, 1'b0, '0},
        // all equal elements
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b1}, 1'b0, '0},
        // already sorted
        '{'{-32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b1}, 1'b0, '0},
        // largest element last: pivot lands at the tail
        '{'{32'sd3, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd2, 1'b0}, 1'b0, '0},
        '{'{32'sd9, 1'b1}, 1'b0, '0},
        // signed extremes mixed
        '{'{32'sh7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
        '{'{32'sh0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'shFFFF_FFFF, 1'b1}, 1'b0, '0},
        // reverse sorted: pivot lands at the head
        '{'{32'sd9, 1'b0}, 1'b0, '0},
        '{'{32'sd8, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{32'sd6, 1'b1}, 1'b0, '0}
    };

    quicksort_sequence_sorter_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    // Free-running clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Lomuto split of held_vals[lo..hi] around the tail element
    function automatic int split_range(int lo, int hi);
        logic signed [qss_pkg::DATA_W-1:0] pivot;
        logic signed [qss_pkg::DATA_W-1:0] tmp;
        int slot;
        int k;
        pivot = held_vals[hi];
        slot = lo;
        for (k = lo; k < hi; k++)
        begin
            if (held_vals[k] < pivot)
            begin
                tmp = held_vals[slot];
                held_vals[slot] = held_vals[k];
                held_vals[k] = tmp;
                slot++;
            end
        end
        tmp = held_vals[slot];
        held_vals[slot] = held_vals[hi];
        held_vals[hi] = tmp;
        return slot;
    endfunction

    // Quicksort of the first n held elements, larger part pushed on a range stack
    function automatic void sort_held(int n);
        int lo_stack [qss_pkg::MAX_ITEMS];
        int hi_stack [qss_pkg::MAX_ITEMS];
        int depth;
        int lo;
        int hi;
        int p;
        if (n < 2)
            return;
        lo_stack[0] = 0;
        hi_stack[0] = n - 1;
        depth = 1;
        while (depth > 0)
        begin
            depth--;
            lo = lo_stack[depth];
            hi = hi_stack[depth];
            while (lo < hi)
            begin
                p = split_range(lo, hi);
                if (p - lo < hi - p)
                begin
                    if (p + 1 < hi && depth < qss_pkg::MAX_ITEMS)
                    begin
                        lo_stack[depth] = p + 1;
                        hi_stack[depth] = hi;
                        depth++;
                    end
                    hi = p - 1;
                end
                else
                begin
                    if (lo + 1 < p && depth < qss_pkg::MAX_ITEMS)
                    begin
                        lo_stack[depth] = lo;
                        hi_stack[depth] = p - 1;
                        depth++;
                    end
                    lo = p + 1;
                end
            end
        end
    endfunction

    // Take one accepted item; on the last one, leave the sorted run in fresh_q
    function automatic void absorb_item(qss_pkg::in_t it);
        qss_pkg::out_t r;
        int k;
        fresh_q.delete();
        if (held_count < qss_pkg::MAX_ITEMS)
        begin
            held_vals[held_count] = it.value;
            held_count++;
        end
        else
            drop_seen = 1'b1;
        if (!it.last)
            return;
        sort_held(held_count);
        for (k = 0; k < held_count; k++)
        begin
            r.sorted_value = held_vals[k];
            r.final_res = (k == held_count - 1);
            r.overflow = drop_seen;
            fresh_q.push_back(r);
        end
        held_count = 0;
        drop_seen = 1'b0;
    endfunction

    // Drive one transaction, wait for acceptance, then idle between bursts
    task automatic push_item(qss_pkg::in_t it, logic typed, qss_pkg::out_t want);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        absorb_item(it);
        if (typed)
            sorted_exp_q.push_back(want);
        else
            foreach (fresh_q[i])
                sorted_exp_q.push_back(fresh_q[i]);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 5);
        end
    endtask

    // Send one run of len items with random values, the last one marked
    task automatic send_run(int len);
        qss_pkg::in_t it;
        int i;
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0: it.value = $urandom_range(0, 8) - 4;
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: it.value = 32'sh7FFF_FFFF;
                        1: it.value = 32'sh8000_0000;
                        2: it.value = '0;
                        default: it.value = '1;
                    endcase
                end
                default: it.value = $urandom;
            endcase
            it.last = (i == len - 1);
            push_item(it, 1'b0, '0);
            random_items++;
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        held_count = 0;
        drop_seen = 1'b0;
        burst_left = 5;
        random_items = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            push_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        // Fill the store exactly, then drop several items including the last
        send_run(qss_pkg::MAX_ITEMS);
        send_run(qss_pkg::MAX_ITEMS + 3);
        while (random_items < 175)
            send_run($urandom_range(1, 12));
        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding results
        while (sorted_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (sorted_exp_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %0d final %0b overflow %0b",
                         $time, "actual value", result.sorted_value,
                         result.final_res, result.overflow);
                mismatch_count++;
            end
            else
            begin
                want_res = sorted_exp_q.pop_front();
                if (result.sorted_value !== want_res.sorted_value)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want_res.sorted_value, result.sorted_value);
                    mismatch_count++;
                end
                if (result.final_res !== want_res.final_res)
                begin
                    $display("%0t: final_res expected %0b actual %0b",
                             $time, want_res.final_res, result.final_res);
                    mismatch_count++;
                end
                if (result.overflow !== want_res.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want_res.overflow, result.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected",
                     $time, sorted_exp_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/qss_pkg.sv
rtl/qss_engine.sv
rtl/quicksort_sequence_sorter_top.sv
tb/sv/tb.sv
